### src/imufd_pkg.sv
// Package for the sensor frame deframer: frame constants and the result record.
// No dependencies; imported by imufd_core and imu_frame_deframer.
`timescale 1ns / 1ps

package imufd_pkg;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] CMD_HMASK  = 8'hf0;
   localparam logic [7:0] CMD_HVAL   = 8'h50;
   localparam logic [7:0] TYPE_FIRST = 8'h51;
   localparam logic [7:0] TYPE_LAST  = 8'h54;
   localparam logic [3:0] TYPE_NMASK = 4'hf;
   localparam logic [3:0] ALL_SEEN   = 4'hf;
   localparam logic [3:0] LAST_INDEX = 4'd10;
   localparam int         STORE_LEN  = 7;
   localparam int         STORE_AW   = $clog2(STORE_LEN);

   typedef struct packed {
      logic [3:0]         frame_type;
      logic signed [15:0] value_x;
      logic signed [15:0] value_y;
      logic signed [15:0] value_z;
      logic               set_complete;
   } frame_result_type;

endpackage

### src/imufd_core.sv
// Frame tracking core: byte counter, running checksum, frame store and seen mask.
// Depends on imufd_pkg.
`timescale 1ns / 1ps

module imufd_core
   import imufd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   output logic             frame_done,
   output frame_result_type result
);

   logic [3:0]          byte_index_ff, byte_index_in;
   logic [7:0]          running_sum_ff, running_sum_in;
   logic [3:0]          seen_mask_ff, seen_mask_in;
   logic [7:0]          frame_store_ff [STORE_LEN];
   logic [3:0]          idx;
   logic                store_we;
   logic [STORE_AW-1:0] store_sel;
   logic [7:0]          cmd;
   logic [3:0]          mask_upd;
   logic [3:0]          type_bit;

   assign idx       = (byte_index_ff > LAST_INDEX) ? 4'd0 : byte_index_ff;
   assign store_sel = STORE_AW'(idx - 4'd1);
   assign cmd       = frame_store_ff[0];

   // one-hot bit for types 1..4, nothing for the other type codes
   always_comb begin
      type_bit = 4'b0000;
      if (cmd >= TYPE_FIRST && cmd <= TYPE_LAST) begin
         type_bit = 4'b0001 << 2'(cmd - TYPE_FIRST);
      end
   end
   assign mask_upd = seen_mask_ff | type_bit;

   always_comb begin
      byte_index_in  = byte_index_ff;
      running_sum_in = running_sum_ff;
      seen_mask_in   = seen_mask_ff;
      store_we       = 1'b0;
      frame_done     = 1'b0;
      if (step) begin
         priority if (idx == 4'd0) begin
            if (rx_byte == HDR_BYTE) begin
               byte_index_in  = 4'd1;
               running_sum_in = rx_byte;
            end else begin
               byte_index_in  = 4'd0;
               running_sum_in = 8'd0;
            end
         end else if (idx == 4'd1) begin
            if ((rx_byte & CMD_HMASK) == CMD_HVAL) begin
               store_we       = 1'b1;
               byte_index_in  = 4'd2;
               running_sum_in = running_sum_ff + rx_byte;
            end else begin
               byte_index_in  = 4'd0;
               running_sum_in = 8'd0;
            end
         end else if (idx < LAST_INDEX) begin
            store_we       = (idx <= 4'(STORE_LEN));
            byte_index_in  = idx + 4'd1;
            running_sum_in = running_sum_ff + rx_byte;
         end else begin
            byte_index_in  = 4'd0;
            running_sum_in = 8'd0;
            if (rx_byte == running_sum_ff) begin
               frame_done   = 1'b1;
               seen_mask_in = (mask_upd == ALL_SEEN) ? 4'd0 : mask_upd;
            end
         end
      end
   end

   always_comb begin
      result.frame_type   = cmd[3:0] & TYPE_NMASK;
      result.value_x      = {frame_store_ff[2], frame_store_ff[1]};
      result.value_y      = {frame_store_ff[4], frame_store_ff[3]};
      result.value_z      = {frame_store_ff[6], frame_store_ff[5]};
      result.set_complete = (mask_upd == ALL_SEEN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= 4'd0;
         running_sum_ff <= 8'd0;
         seen_mask_ff   <= 4'd0;
      end else begin
         byte_index_ff  <= byte_index_in;
         running_sum_ff <= running_sum_in;
         seen_mask_ff   <= seen_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_store_ff[store_sel] <= rx_byte;
      end
   end

endmodule

### src/imu_frame_deframer.sv
// Sensor frame deframer top level: input register, frame core, result register.
// A frame's result passes from the input register through the core into the
// result register, which drives the result channel. Throughput: one byte
// per cycle unless a stalled result blocks it; each byte takes a single core pass.
// Reset (synchronous, active high) empties both registers and restarts the frame
// search with an empty seen mask. Depends on imufd_pkg and imufd_core.
`timescale 1ns / 1ps

module imu_frame_deframer
   import imufd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel: one received byte per request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   // result channel: one result per good frame
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [3:0]         rsp_frame_type,
   output logic signed [15:0] rsp_value_x,
   output logic signed [15:0] rsp_value_y,
   output logic signed [15:0] rsp_value_z,
   output logic               rsp_set_complete
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   frame_result_type out_ff;
   frame_result_type core_result;
   logic             core_done;
   logic             advance;
   logic             step;

   // The held byte may move into the core whenever the result register is
   // empty or is being drained this cycle.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   // Hold the request only while a byte waits in the input register and
   // cannot advance.
   assign req_stall = in_valid_ff && !advance;

   imufd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .frame_done (core_done),
      .result     (core_result)
   );

   // Input register: load on every accepted request, drop once consumed.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: load on a finished frame, clear once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (step && core_done) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
      if (step && core_done) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_type   = out_ff.frame_type;
   assign rsp_value_x      = out_ff.value_x;
   assign rsp_value_y      = out_ff.value_y;
   assign rsp_value_z      = out_ff.value_z;
   assign rsp_set_complete = out_ff.set_complete;

endmodule

### tb/imu_frame_deframer_tb.sv
// Self-checking testbench for the sensor frame deframer: streams byte requests,
// predicts each good frame's result and checks the result channel against it.
// Depends on imufd_pkg and the imu_frame_deframer RTL.
`timescale 1ns / 1ps

module imu_frame_deframer_tb;
   import imufd_pkg::*;

   // Frame type nibbles that take part in the seen set
   localparam logic [3:0] TYPE_ACCEL = 4'd1;
   localparam logic [3:0] TYPE_GYRO  = 4'd2;
   localparam logic [3:0] TYPE_ANGLE = 4'd3;
   localparam logic [3:0] TYPE_MAG   = 4'd4;
   // Nibbles outside the set, still reported
   localparam logic [3:0] TYPE_NONE  = 4'd0;
   localparam logic [3:0] TYPE_MID   = 4'd5;
   localparam logic [3:0] TYPE_TOP   = 4'd15;

   localparam int RANDOM_BYTES = 880;
   localparam int IDLE_PCT     = 22;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [3:0]         rsp_frame_type;
   logic signed [15:0] rsp_value_x;
   logic signed [15:0] rsp_value_y;
   logic signed [15:0] rsp_value_z;
   logic               rsp_set_complete;

   // Predictor state: position in the frame, running checksum, command and
   // data bytes 0..5, and the mask of seen types
   logic [3:0] frame_pos = 4'd0;
   logic [7:0] frame_sum = 8'h00;
   logic [7:0] frame_bytes [0:STORE_LEN-1];
   logic [3:0] types_seen = 4'h0;

   frame_result_type pending_frames [$];

   bit quiet = 1'b0;   // suppress idling on both sides while set
   int fails = 0;
   int bytes_sent = 0;
   int frames_checked = 0;
   int sets_checked = 0;
   int bad_sums_sent = 0;

   imu_frame_deframer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_value_x      (rsp_value_x),
      .rsp_value_y      (rsp_value_y),
      .rsp_value_z      (rsp_value_z),
      .rsp_set_complete (rsp_set_complete)
   );

   always #2 clock = ~clock;

   // Stall the result side at random unless a quiet stretch is running.
   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
   end

   // Advance the predictor by one accepted byte; queue a result when a frame
   // closes with a matching checksum.
   task automatic track_byte(input logic [7:0] rx);
      frame_result_type res;
      logic [3:0] idx;
      logic [7:0] cmd;
      idx = (frame_pos > LAST_INDEX) ? 4'd0 : frame_pos;
      if (idx == 4'd0) begin
         // Wait for a header; anything else is dropped
         if (rx == HDR_BYTE) begin
            frame_sum = rx;
            frame_pos = 4'd1;
         end else begin
            frame_sum = 8'h00;
            frame_pos = 4'd0;
         end
      end else if (idx == 4'd1) begin
         // A bad command restarts the search and is not retried as a header
         if ((rx & CMD_HMASK) == CMD_HVAL) begin
            frame_bytes[0] = rx;
            frame_sum = frame_sum + rx;
            frame_pos = 4'd2;
         end else begin
            frame_sum = 8'h00;
            frame_pos = 4'd0;
         end
      end else if (idx < LAST_INDEX) begin
         // Data bytes 6 and 7 only feed the checksum
         if (idx - 1 < STORE_LEN)
            frame_bytes[idx - 1] = rx;
         frame_sum = frame_sum + rx;
         frame_pos = idx + 4'd1;
      end else begin
         if (rx == frame_sum) begin
            cmd = frame_bytes[0];
            if (cmd >= TYPE_FIRST && cmd <= TYPE_LAST)
               types_seen = types_seen | (4'b0001 << (cmd - TYPE_FIRST));
            res.set_complete = (types_seen == ALL_SEEN);
            if (res.set_complete)
               types_seen = 4'h0;
            res.frame_type = cmd[3:0] & TYPE_NMASK;
            res.value_x = {frame_bytes[2], frame_bytes[1]};
            res.value_y = {frame_bytes[4], frame_bytes[3]};
            res.value_z = {frame_bytes[6], frame_bytes[5]};
            pending_frames.push_back(res);
         end
         frame_sum = 8'h00;
         frame_pos = 4'd0;
      end
   endtask

   // Send one byte request: idle a random number of cycles first, then hold
   // the byte until it is taken, then update the predictor.
   task automatic send_byte(input logic [7:0] rx);
      int gap;
      gap = 0;
      while (!quiet && $urandom_range(99) < IDLE_PCT)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      track_byte(rx);
   endtask

   // Send a whole frame; payload holds data bytes 0..7 with byte 0 lowest.
   // A nonzero sum_flip corrupts the checksum byte.
   task automatic send_frame(input logic [3:0] kind, input logic [63:0] payload,
                             input logic [7:0] sum_flip);
      logic [7:0] cmd;
      logic [7:0] sum;
      cmd = CMD_HVAL | {4'h0, kind};
      sum = HDR_BYTE + cmd;
      send_byte(HDR_BYTE);
      send_byte(cmd);
      for (int k = 0; k < 8; k++) begin
         sum = sum + payload[8*k +: 8];
         send_byte(payload[8*k +: 8]);
      end
      if (sum_flip != 8'h00)
         bad_sums_sent++;
      send_byte(sum ^ sum_flip);
   endtask

   function automatic logic [63:0] random_payload();
      return {$urandom, $urandom};
   endfunction

   // Check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: type %0h x %0d y %0d z %0d set %0b",
                   rsp_frame_type, rsp_value_x, rsp_value_y, rsp_value_z,
                   rsp_set_complete);
            fails++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (want.set_complete)
               sets_checked++;
            if (rsp_frame_type !== want.frame_type) begin
               $error("frame_type: expected %0h, got %0h", want.frame_type, rsp_frame_type);
               fails++;
            end
            if (rsp_value_x !== want.value_x) begin
               $error("value_x: expected %0d, got %0d", want.value_x, rsp_value_x);
               fails++;
            end
            if (rsp_value_y !== want.value_y) begin
               $error("value_y: expected %0d, got %0d", want.value_y, rsp_value_y);
               fails++;
            end
            if (rsp_value_z !== want.value_z) begin
               $error("value_z: expected %0d, got %0d", want.value_z, rsp_value_z);
               fails++;
            end
            if (rsp_set_complete !== want.set_complete) begin
               $error("set_complete: expected %0b, got %0b",
                      want.set_complete, rsp_set_complete);
               fails++;
            end
         end
      end
   end

   // Each of the four types once with extreme words, then a second set built
   // from repeats so that duplicates do not complete it early.
   task automatic test_full_sets();
      send_frame(TYPE_ACCEL, {16'hffff, 16'h8000, 16'hffff, 16'h0000}, 8'h00);
      send_frame(TYPE_GYRO,  {16'h0000, 16'h0001, 16'h8000, 16'h7fff}, 8'h00);
      send_frame(TYPE_ANGLE, {16'h00ff, 16'hff00, 16'h7fff, 16'h8000}, 8'h00);
      send_frame(TYPE_MAG,   {16'hff00, 16'h0000, 16'h0000, 16'hffff}, 8'h00);
      send_frame(TYPE_MAG,   random_payload(), 8'h00);
      send_frame(TYPE_MAG,   random_payload(), 8'h00);
      send_frame(TYPE_ACCEL, random_payload(), 8'h00);
      send_frame(TYPE_GYRO,  random_payload(), 8'h00);
      send_frame(TYPE_ANGLE, random_payload(), 8'h00);
   endtask

   // Type nibbles outside 1..4 are reported but leave the seen mask alone.
   task automatic test_other_types();
      send_frame(TYPE_ACCEL, random_payload(), 8'h00);
      send_frame(TYPE_NONE,  random_payload(), 8'h00);
      send_frame(TYPE_GYRO,  random_payload(), 8'h00);
      send_frame(TYPE_MID,   random_payload(), 8'h00);
      send_frame(TYPE_ANGLE, random_payload(), 8'h00);
      send_frame(TYPE_TOP,   random_payload(), 8'h00);
      send_frame(TYPE_MAG,   random_payload(), 8'h00);
   endtask

   // Bad header, bad command and bad checksum each drop the frame; a dropped
   // magnetic frame must not finish the set.
   task automatic test_framing_errors();
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'haa);
      send_frame(TYPE_ACCEL, random_payload(), 8'h00);
      send_byte(HDR_BYTE);
      send_byte(8'h45);
      send_frame(TYPE_GYRO, random_payload(), 8'h00);
      send_byte(HDR_BYTE);
      send_byte(8'hd5);
      send_byte(HDR_BYTE);
      send_byte(8'h05);
      send_frame(TYPE_ANGLE, random_payload(), 8'h00);
      send_frame(TYPE_MAG, random_payload(), 8'h01);
      send_frame(TYPE_MAG, random_payload(), 8'h80);
      send_frame(TYPE_MAG, random_payload(), 8'h00);
   endtask

   // Mostly good frames with random content, mixed with corrupt checksums,
   // noise bytes, bad commands and truncated frames.
   task automatic test_random_stream(input int n_bytes);
      int start;
      int pick;
      logic [3:0] kind;
      logic [7:0] junk;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) < 85)
            kind = 4'($urandom_range(TYPE_ACCEL, TYPE_MAG));
         else
            kind = 4'($urandom_range(15));
         if (pick < 70) begin
            send_frame(kind, random_payload(), 8'h00);
         end else if (pick < 80) begin
            send_frame(kind, random_payload(), 8'($urandom_range(1, 255)));
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
         end else if (pick < 94) begin
            junk = 8'($urandom_range(255));
            if ((junk & CMD_HMASK) == CMD_HVAL)
               junk = junk ^ 8'h80;
            send_byte(HDR_BYTE);
            send_byte(junk);
         end else begin
            // Cut a frame short; its tail swallows the bytes that follow
            send_byte(HDR_BYTE);
            send_byte(CMD_HVAL | {4'h0, kind});
            repeat ($urandom_range(0, 7)) send_byte(8'($urandom_range(255)));
         end
      end
   endtask

   // Run good frames with no idling on either side.
   task automatic test_back_to_back();
      quiet = 1'b1;
      repeat (24)
         send_frame(4'($urandom_range(TYPE_ACCEL, TYPE_MAG)), random_payload(), 8'h00);
      quiet = 1'b0;
   endtask

   initial begin
      int waited;
      for (int k = 0; k < STORE_LEN; k++)
         frame_bytes[k] = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_sets();
      test_other_types();
      test_framing_errors();
      test_random_stream(RANDOM_BYTES / 2);
      test_back_to_back();
      test_random_stream(RANDOM_BYTES / 2);
      req_valid <= 1'b0;

      // Drain the outstanding results, then allow for the pipeline latency
      waited = 0;
      while (pending_frames.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $error("%0d predicted results never arrived", pending_frames.size());
         fails++;
      end

      $display("Sent %0d bytes including %0d frames with corrupt checksums.",
               bytes_sent, bad_sums_sent);
      $display("Checked %0d frame results, %0d of them closing a full type set.",
               frames_checked, sets_checked);
      if (fails == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Stop a hung run.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
